@@ rtl/box_filter_mip_chain_assert.svh @@
// ---------------------------------------------------------------------------
// box_filter_mip_chain_assert: assertion macros for the box filter mip chain
// Clocked implication checks, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef BOX_FILTER_MIP_CHAIN_ASSERT_SVH
`define BOX_FILTER_MIP_CHAIN_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define BFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/bfm_pkg.sv @@
// ---------------------------------------------------------------------------
// bfm_pkg: shared types for the box filter mip chain
// Controller states, command and status structs, config indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package bfm_pkg;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 13;
  localparam logic [CfgIdxWidth-1:0] CfgWidth = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgHeight = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgChans = 2'd2;
  localparam int unsigned LvlWidth = 4;
  localparam int unsigned PosWidth = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic load;     // capture input pixel, start at level 0
    logic rd;       // issue line buffer read for current level
    logic emit;     // register result and advance level
  } ctl_cmd_t;

  typedef struct packed {
    logic done;     // current level result is last of this item
  } ctl_sts_t;
endpackage
`default_nettype wire

@@ rtl/bfm_stream_if.sv @@
// ---------------------------------------------------------------------------
// bfm_stream_if: valid/ready channel
// Carries one beat of payload of type given by a width parameter.
// ---------------------------------------------------------------------------
`default_nettype none
interface bfm_stream_if #(
  parameter int unsigned DataWidth = 32
);
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/box_filter_mip_chain.sv @@
// ---------------------------------------------------------------------------
// box_filter_mip_chain: 2x2 box filter mip chain, one base pixel in per item
// The first result beat is registered on emit, after the read state that follows the pixel beat.
// Per item: a load, then read+emit per level; no new pixel is taken until the last emit.
// Reset restores 256x256, four channels, all level positions at zero.
// ---------------------------------------------------------------------------
`default_nettype none
module box_filter_mip_chain #(
  parameter int unsigned MAX_DIM = 4096,
  parameter int unsigned MAX_LEVELS = 12,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bfm_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [bfm_pkg::CfgDataWidth-1:0]   cfg_data_i,
  bfm_stream_if.sink                              pix_in,
  bfm_stream_if.source                            mip_out
);
  // payload layouts (low to high bits)
  // in : pix_c0 pix_c1 pix_c2 pix_c3
  // out: out_c0..out_c3 [31:0], pos_y [43:32], pos_x [55:44], mip_level [59:56],
  //      run_last [60]
  // A receiver stall holds the controller in emit and extends the item's cycles.
  bfm_pkg::ctl_cmd_t cmd;
  bfm_pkg::ctl_sts_t sts;
  logic [bfm_pkg::LvlWidth-1:0] lvl;
  logic [bfm_pkg::PosWidth-1:0] px, py;
  logic [31:0] val;
  logic out_valid_q;
  logic [60:0] out_q;
  logic out_free;

  // output register frees when empty or taken this cycle
  assign out_free = !out_valid_q || mip_out.ready;

  bfm_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(pix_in.valid), .in_ready_o(pix_in.ready),
    .out_free_i(out_free), .sts_i(sts), .cmd_o(cmd)
  );

  bfm_datapath #(
    .MaxDim(MAX_DIM), .MaxLevels(MAX_LEVELS), .MaxChannels(MAX_CHANNELS)
  ) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .pix_i(pix_in.data[31:0]), .cmd_i(cmd), .sts_o(sts),
    .lvl_o(lvl), .x_o(px), .y_o(py), .val_o(val)
  );

  // hold each beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.emit) out_valid_q <= 1'b1;
    else if (mip_out.ready) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd.emit) out_q <= {sts.done, lvl, px, py, val};
  end
  assign mip_out.valid = out_valid_q;
  assign mip_out.data = out_q;

  `include "box_filter_mip_chain_assert.svh"
  `BFM_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd.emit, out_free, "emit into busy out reg")
  `BFM_ASSERT_IMPL(a_load_excl, clk_i, rst_ni, cmd.load, !cmd.emit && !cmd.rd, "load overlap")
  `BFM_ASSERT_NEXT(a_load_rd, clk_i, rst_ni, cmd.load, cmd.rd, "no read after load")
endmodule
`default_nettype wire

@@ rtl/bfm_ctrl.sv @@
// ---------------------------------------------------------------------------
// bfm_ctrl: sequencer for the mip cascade
// Steps one level at a time: buffer read, then emit, held in emit while the output is busy.
// ---------------------------------------------------------------------------
`default_nettype none
module bfm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            out_free_i,
  input  bfm_pkg::ctl_sts_t    sts_i,
  output bfm_pkg::ctl_cmd_t    cmd_o
);
  bfm_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bfm_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bfm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = bfm_pkg::ST_READ;
        end
      end
      bfm_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d = bfm_pkg::ST_EMIT;
      end
      bfm_pkg::ST_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.done ? bfm_pkg::ST_IDLE : bfm_pkg::ST_READ;
        end
      end
      default: state_d = bfm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/bfm_datapath.sv @@
// ---------------------------------------------------------------------------
// bfm_datapath: per-level positions, pair sums, line buffer, averaging
// Works one level per step under controller command.
// ---------------------------------------------------------------------------
`default_nettype none
module bfm_datapath #(
  parameter int unsigned MaxDim = 4096,
  parameter int unsigned MaxLevels = 12,
  parameter int unsigned MaxChannels = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [12:0]           cfg_data_i,
  input  wire logic [31:0]           pix_i,
  input  bfm_pkg::ctl_cmd_t          cmd_i,
  output bfm_pkg::ctl_sts_t          sts_o,
  output logic [3:0]                 lvl_o,
  output logic [11:0]                x_o,
  output logic [11:0]                y_o,
  output logic [31:0]                val_o
);
  localparam int unsigned DimW = $clog2(MaxDim + 1);
  localparam int unsigned AddrW = $clog2(MaxDim);
  localparam int unsigned NLvl = MaxLevels + 1;
  localparam int unsigned LvlW = $clog2(NLvl + 1);
  localparam int unsigned SumW = 10;

  logic [12:0] cfg_w_q, cfg_h_q;
  logic [2:0]  cfg_c_q;
  logic [DimW-1:0] col_q [NLvl];
  logic [DimW-1:0] row_q [NLvl];
  logic [4*SumW-1:0] pend_q [MaxLevels];
  logic [4*SumW-1:0] mem_q [MaxDim];
  logic [4*SumW-1:0] rd_q;

  logic [LvlW-1:0] lvl_q;
  logic [DimW-1:0] w_q, h_q, off_q;
  logic [4*SumW-1:0] val_q;     // current level value, 10b per channel
  logic restart;

  // saturated sizes
  logic [DimW-1:0] w0, h0;
  logic [2:0] ch;
  always_comb begin
    w0 = (cfg_w_q == 13'd0) ? DimW'(1) :
         (32'(cfg_w_q) > MaxDim) ? DimW'(MaxDim) : DimW'(cfg_w_q);
    h0 = (cfg_h_q == 13'd0) ? DimW'(1) :
         (32'(cfg_h_q) > MaxDim) ? DimW'(MaxDim) : DimW'(cfg_h_q);
    ch = (cfg_c_q == 3'd0) ? 3'd1 :
         (32'(cfg_c_q) > MaxChannels) ? 3'(MaxChannels) : cfg_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 13'd256;
      cfg_h_q <= 13'd256;
      cfg_c_q <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfm_pkg::CfgWidth:  cfg_w_q <= cfg_data_i;
        bfm_pkg::CfgHeight: cfg_h_q <= cfg_data_i;
        bfm_pkg::CfgChans:  cfg_c_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end
  assign restart = cfg_we_i && (cfg_idx_i == bfm_pkg::CfgWidth ||
                                cfg_idx_i == bfm_pkg::CfgHeight ||
                                cfg_idx_i == bfm_pkg::CfgChans);

  // current level state
  logic [DimW-1:0] x, y;
  logic [LvlW-1:0] li;
  assign li = lvl_q;
  assign x = col_q[li];
  assign y = row_q[li];

  logic [DimW-1:0] col_idx;
  logic [DimW:0] idx;
  logic w1, h1, stop, hpass, vpass, vwrite, pwrite;
  logic [4*SumW-1:0] hsum, vsum, nval;
  logic [1:0] shift;

  always_comb begin
    w1 = (w_q == DimW'(1));
    h1 = (h_q == DimW'(1));
    stop = (32'(lvl_q) >= MaxLevels) || (w1 && h1);
    hpass = 1'b0;
    pwrite = 1'b0;
    col_idx = '0;
    shift = 2'd0;
    hsum = val_q;
    if (w1) begin
      hpass = 1'b1;
    end else if (!x[0]) begin
      pwrite = (32'(x) + 1 < 32'(w_q));
    end else begin
      hpass = 1'b1;
      col_idx = x >> 1;
      shift = 2'd1;
      for (int c = 0; c < 4; c++)
        hsum[c*SumW +: SumW] = pend_q[li[$clog2(MaxLevels+1)-1:0] < MaxLevels ?
          li[$clog2(MaxLevels+1)-1:0] : '0][c*SumW +: SumW] + val_q[c*SumW +: SumW];
    end
    idx = (DimW+1)'(off_q) + (DimW+1)'(col_idx);
    vpass = hpass && (h1 || y[0]);
    vwrite = hpass && !h1 && !y[0] && (32'(y) + 1 < 32'(h_q)) && (32'(idx) < MaxDim);
    vsum = hsum;
    if (!h1) begin
      shift = shift + 2'd1;
      for (int c = 0; c < 4; c++)
        vsum[c*SumW +: SumW] = hsum[c*SumW +: SumW] +
          ((32'(idx) < MaxDim) ? rd_q[c*SumW +: SumW] : '0);
    end
    for (int c = 0; c < 4; c++)
      nval[c*SumW +: SumW] = SumW'(vsum[c*SumW +: SumW] >> shift) & SumW'(8'hFF);
  end

  assign sts_o.done = stop || !vpass;

  // line buffer read, issued in the read state ahead of emit
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem_q[idx[AddrW-1:0]];
    if (cmd_i.emit && !stop && vwrite) mem_q[idx[AddrW-1:0]] <= hsum;
    if (cmd_i.emit && !stop && !w1 && !x[0] && pwrite)
      pend_q[li[$clog2(MaxLevels+1)-1:0]] <= val_q;
  end

  // level walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
      for (int l = 0; l < NLvl; l++) begin
        col_q[l] <= '0;
        row_q[l] <= '0;
      end
    end else if (restart) begin
      for (int l = 0; l < NLvl; l++) begin
        col_q[l] <= '0;
        row_q[l] <= '0;
      end
    end else begin
      if (cmd_i.load) lvl_q <= '0;
      if (cmd_i.emit) begin
        if (32'(x) + 1 >= 32'(w_q)) begin
          col_q[li] <= '0;
          row_q[li] <= (32'(y) + 1 >= 32'(h_q)) ? '0 : y + DimW'(1);
        end else begin
          col_q[li] <= x + DimW'(1);
        end
        lvl_q <= lvl_q + LvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= w0;
      h_q <= h0;
      off_q <= '0;
      for (int c = 0; c < 4; c++)
        val_q[c*SumW +: SumW] <= (3'(c) < ch) ? {2'b00, pix_i[c*8 +: 8]} : '0;
    end else if (cmd_i.emit) begin
      val_q <= nval;
      w_q <= w1 ? w_q : (w_q >> 1);
      h_q <= h1 ? h_q : (h_q >> 1);
      off_q <= off_q + (w1 ? w_q : (w_q >> 1));
    end
  end

  assign lvl_o = 4'(lvl_q);
  assign x_o = 12'(x);
  assign y_o = 12'(y);
  always_comb
    for (int c = 0; c < 4; c++) val_o[c*8 +: 8] = val_q[c*SumW +: 8];
endmodule
`default_nettype wire

@@ tb/box_filter_mip_chain_tb.sv @@
// ---------------------------------------------------------------------------
// box_filter_mip_chain_tb: self-checking bench for the mip chain generator
// Streams base pixels through several image geometries and channel counts,
// predicts every level pixel with an in-bench box filter and checks each
// output beat in order, under random and long back-pressure on both sides.
// ---------------------------------------------------------------------------
`default_nettype none
module box_filter_mip_chain_tb;
  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned MaxLevels = 12;
  localparam int unsigned OutWidth  = 61;

  // Field order matches the output beat, MSB first.
  typedef struct packed {
    logic        last;
    logic [3:0]  level;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  c3;
    logic [7:0]  c2;
    logic [7:0]  c1;
    logic [7:0]  c0;
  } mip_pix_t;

  typedef struct packed {
    logic [7:0] c3;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } base_pix_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;

  bfm_stream_if #(.DataWidth(32))       pix_in ();
  bfm_stream_if #(.DataWidth(OutWidth)) mip_out ();

  box_filter_mip_chain dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_in    (pix_in.sink),
    .mip_out   (mip_out.source)
  );

  // Clock: period 12.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Filter model state: shadow registers plus line buffers and positions.
  logic [12:0]     shadow_width;
  logic [12:0]     shadow_height;
  logic [2:0]      shadow_chans;
  int unsigned     line_sums [MaxDim][4];
  int unsigned     left_pix  [MaxLevels][4];
  int unsigned     lvl_col   [MaxLevels+1];
  int unsigned     lvl_row   [MaxLevels+1];

  base_pix_t       base_queue [$];   // pixels waiting to be offered
  mip_pix_t        mip_queue  [$];   // level pixels still owed by the block

  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  logic            tx_pause;
  logic            rx_blocked = 1'b0;
  logic            rx_block_req;
  int unsigned     mismatches;

  function automatic int unsigned clamp_size(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i <= MaxLevels; i++) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
  endfunction

  function automatic void add_pixel(base_pix_t p);
    base_queue.insert(base_queue.size(), p);
  endfunction

  // Run one base pixel down the cascade; queue every pixel it finishes.
  function automatic void filter_pixel(base_pix_t p);
    int unsigned w, h, chans, off, lvl, x, y, col, shift, idx, nw, nh;
    int unsigned v [4];
    int unsigned hs [4];
    logic [7:0]  raw [4];
    mip_pix_t    r;
    bit          stop;
    w     = clamp_size(shadow_width);
    h     = clamp_size(shadow_height);
    chans = (shadow_chans == 0) ? 1 : (shadow_chans > 4) ? 4 : shadow_chans;
    raw   = '{p.c0, p.c1, p.c2, p.c3};
    for (int c = 0; c < 4; c++) v[c] = (c < chans) ? raw[c] : 0;
    off  = 0;
    lvl  = 0;
    stop = 1'b0;
    while (!stop) begin
      x = lvl_col[lvl];
      y = lvl_row[lvl];
      r = '{level: lvl[3:0], x: x[11:0], y: y[11:0], c0: v[0][7:0], c1: v[1][7:0],
            c2: v[2][7:0], c3: v[3][7:0], last: 1'b0};
      mip_queue.insert(mip_queue.size(), r);
      // advance this level's raster position, wrap at end of frame
      if (lvl_col[lvl] + 1 >= w) begin
        lvl_col[lvl] = 0;
        lvl_row[lvl] = (lvl_row[lvl] + 1 >= h) ? 0 : lvl_row[lvl] + 1;
      end else begin
        lvl_col[lvl]++;
      end
      if (lvl >= MaxLevels || (w == 1 && h == 1)) break;
      shift = 0;
      col   = 0;
      if (w == 1) begin
        hs = v;
      end else if (x[0] == 1'b0) begin
        if (x + 1 < w) for (int c = 0; c < 4; c++) left_pix[lvl][c] = v[c];
        break;
      end else begin
        for (int c = 0; c < 4; c++) hs[c] = left_pix[lvl][c] + v[c];
        col   = x >> 1;
        shift = 1;
      end
      if (h != 1) begin
        idx = off + col;
        if (y[0] == 1'b0) begin
          if (y + 1 < h && idx < MaxDim)
            for (int c = 0; c < 4; c++) line_sums[idx][c] = hs[c];
          break;
        end
        for (int c = 0; c < 4; c++) hs[c] += (idx < MaxDim) ? line_sums[idx][c] : 0;
        shift++;
      end
      for (int c = 0; c < 4; c++) v[c] = (hs[c] >> shift) & 8'hFF;
      nw  = (w > 1) ? (w >> 1) : 1;
      nh  = (h > 1) ? (h >> 1) : 1;
      off += nw;
      w   = nw;
      h   = nh;
      lvl++;
    end
    mip_queue[$].last = 1'b1;
  endfunction

  // Driver: hold a stalled beat, otherwise offer the next pixel or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
      pix_in.data  <= '0;
    end else if (!pix_in.valid || pix_in.ready) begin
      if (base_queue.size() > 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
        pix_in.data  <= base_queue.pop_front();
        pix_in.valid <= 1'b1;
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls, or held low during a long block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mip_out.ready <= 1'b0;
    else mip_out.ready <= !rx_blocked && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long receiver hold-off, counted here while the sender keeps pushing.
  always @(posedge rx_block_req) begin
    rx_blocked <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_blocked <= 1'b0;
  end

  // Monitor: predict on every accepted pixel, check every accepted result.
  always @(posedge clk_i) begin
    mip_pix_t got, want;
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready) filter_pixel(base_pix_t'(pix_in.data));
      if (mip_out.valid && mip_out.ready) begin
        got = mip_pix_t'(mip_out.data);
        if (mip_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = mip_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == bfm_pkg::CfgWidth) shadow_width = val;
    else if (idx == bfm_pkg::CfgHeight) shadow_height = val;
    else shadow_chans = val[2:0];
    restart_frame();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every pixel went in and every result came out, then settle.
  task automatic drain();
    wait (base_queue.size() == 0 && !pix_in.valid && mip_queue.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [2:0] ch);
    drain();
    write_reg(bfm_pkg::CfgWidth, w);
    write_reg(bfm_pkg::CfgHeight, h);
    write_reg(bfm_pkg::CfgChans, {10'd0, ch});
  endtask

  task automatic queue_random(int unsigned n);
    for (int i = 0; i < n; i++) add_pixel(base_pix_t'($urandom()));
  endtask

  initial begin
    int unsigned w, h, frames;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = bfm_pkg::CfgWidth;
    cfg_data_i    = '0;
    tx_pause      = 1'b0;
    rx_block_req  = 1'b0;
    tx_idle_pct   = 6;
    rx_idle_pct   = 55;
    mismatches    = 0;
    shadow_width  = 13'd256;
    shadow_height = 13'd256;
    shadow_chans  = 3'd4;
    restart_frame();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: extremes and alternating bit patterns.
    add_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
    add_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add_pixel('{8'hAA, 8'h55, 8'hFF, 8'h00});
    add_pixel('{8'h55, 8'hAA, 8'h00, 8'hFF});
    queue_random(6);

    // Zero sizes act as 1x1, zero channels as one: every pixel is its own chain.
    set_geometry(13'd0, 13'd0, 3'd0);
    add_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_random(3);

    // 4x4 with oversized channel count: full chain to 1x1 with a frame wrap.
    set_geometry(13'd4, 13'd4, 3'd7);
    for (int i = 0; i < 16; i++) add_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_random(6);

    // Saturated width, single row: first pixels of a wide 1-high chain.
    set_geometry(13'h1FFF, 13'd1, 3'd1);
    queue_random(8);

    // Saturated height, two columns: a 1-wide column chain.
    set_geometry(13'd2, 13'h1FFF, 3'd2);
    queue_random(12);

    // Random geometries; idle profile switches by thirds.
    for (int iter = 0; iter < 9; iter++) begin
      if (iter >= 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (iter >= 3) begin
        tx_idle_pct = 55;
        rx_idle_pct = 6;
      end
      w      = $urandom_range(5, 1);
      h      = $urandom_range(5, 1);
      frames = $urandom_range(2, 1);
      set_geometry(w[12:0], h[12:0], 3'($urandom_range(7, 0)));
      if ($urandom_range(3) == 0) begin
        queue_random($urandom_range(w * h, 1));
      end else begin
        queue_random(w * h * frames);
      end
      // Once: block the receiver so the block fills and stalls its input.
      if (iter == 1) begin
        rx_block_req = 1'b1;
        queue_random(20);
      end
      // Once: pause the sender mid-frame until all results are home.
      if (iter == 4) begin
        wait (base_queue.size() < 3);
        tx_pause = 1'b1;
        wait (!pix_in.valid && mip_queue.size() == 0);
        tx_pause = 1'b0;
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && mip_queue.size() == 0) begin
      $display("box_filter_mip_chain regression: pass");
    end else begin
      $display("box_filter_mip_chain regression: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("box_filter_mip_chain regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/bfm_pkg.sv
rtl/bfm_stream_if.sv
rtl/bfm_ctrl.sv
rtl/bfm_datapath.sv
rtl/box_filter_mip_chain.sv
tb/box_filter_mip_chain_tb.sv
